// ----- design/pdp_pkg.sv -----
// Package for the pixel delta predictor: payload structs, format codes,
// register indexes and the depth clamp value.
package pdp_pkg;

    localparam int MaxPlanes = 6;
    localparam int Channels  = 6;

    localparam logic [1:0] FMT_DEPTH = 2'd0;
    localparam logic [1:0] FMT_PLANE = 2'd1;
    localparam logic [1:0] FMT_RGB   = 2'd2;
    localparam logic [1:0] FMT_RGBA  = 2'd3;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_PLANES = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;

    localparam logic [23:0] DepthMax = 24'hffffff;

    typedef struct packed {
        logic [31:0] depth_bits;
        logic [7:0]  byte_5;
        logic [7:0]  byte_4;
        logic [7:0]  byte_3;
        logic [7:0]  byte_2;
        logic [7:0]  byte_1;
        logic [7:0]  byte_0;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] res_5;
        logic [7:0] res_4;
        logic [7:0] res_3;
        logic [7:0] res_2;
        logic [7:0] res_1;
        logic [7:0] res_0;
        logic       last_in_row;
    } t_pix_out;

    typedef struct packed {
        logic [1:0]  format;
        logic [2:0]  plane_count;
        logic [15:0] row_width;
    } t_cfg;

endpackage

// ----- design/pdp_depth.sv -----
// Depth conversion: float32 times 16777215 in single precision, truncated.
// Depends on pdp_pkg.
module pdp_depth import pdp_pkg::*; (
    input  logic [31:0] i_bits,
    output logic [23:0] o_fixed
);
    // f * (2^24 - 1) = m*2^24 - m, m = 24-bit significand; round to 24 bits
    logic [7:0]  exp_f;
    logic [23:0] man;
    logic [47:0] prod;
    logic        top;
    logic [23:0] sig;
    logic        rbit;
    logic        sticky;
    logic [24:0] sig_r;
    logic [9:0]  e_val;
    logic [23:0] sig_n;
    logic [9:0]  e_n;
    logic [4:0]  sh;

    always_comb begin
        exp_f  = i_bits[30:23];
        man    = {(exp_f != 8'd0), i_bits[22:0]};
        prod   = {man, 24'd0} - {24'd0, man};
        top    = prod[47];
        // normalize: product has leading bit at 47 or 46 for normal inputs
        sig    = top ? prod[47:24] : prod[46:23];
        rbit   = top ? prod[23] : prod[22];
        sticky = top ? (prod[22:0] != 23'd0) : (prod[21:0] != 22'd0);
        sig_r  = {1'b0, sig} + {24'd0, rbit & (sticky | sig[0])};
        // value = sig * 2^(e_val - 23), e_val unbiased exponent of product
        e_val  = {2'd0, exp_f} - 10'd104 + (top ? 10'd1 : 10'd0);
        sig_n  = sig_r[24] ? sig_r[24:1] : sig_r[23:0];
        e_n    = e_val + (sig_r[24] ? 10'd1 : 10'd0);
        sh     = 5'd23 - e_n[4:0];
        if (i_bits[31] || exp_f == 8'd0 || (exp_f == 8'hff && i_bits[22:0] != 23'd0)) begin
            o_fixed = '0;   // negative, zero, subnormal (product < 1) or NaN
        end else if (exp_f == 8'hff || (!e_n[9] && e_n >= 10'd24)) begin
            o_fixed = DepthMax;
        end else if (e_n[9]) begin
            o_fixed = '0;   // below one
        end else begin
            o_fixed = sig_n >> sh;
        end
    end
endmodule

// ----- design/pdp_datapath.sv -----
// Channel value selection, color transform and delta against history.
// Depends on pdp_pkg and pdp_depth.
module pdp_datapath import pdp_pkg::*; (
    input  t_pix_in                    i_pix,
    input  t_cfg                       i_cfg,
    input  logic                       i_row_start,
    input  logic [Channels-1:0][7:0]   i_prev,
    output logic [Channels-1:0][7:0]   o_val,
    output logic [Channels-1:0]        o_used,
    output logic [Channels-1:0][7:0]   o_res
);
    logic [23:0] fixed;
    logic [2:0]  n;
    logic [7:0]  prv;

    pdp_depth u_depth (.i_bits(i_pix.depth_bits), .o_fixed(fixed));

    always_comb begin
        n = (i_cfg.plane_count == 3'd0) ? 3'd1 :
            (i_cfg.plane_count > 3'(MaxPlanes)) ? 3'(MaxPlanes) : i_cfg.plane_count;
        o_val  = '0;
        o_used = '0;
        unique case (i_cfg.format)
            FMT_DEPTH: begin
                o_val[0] = fixed[7:0];
                o_val[1] = fixed[15:8];
                o_val[2] = fixed[23:16];
                o_used   = 6'b000111;
            end
            FMT_PLANE: begin
                o_val = {i_pix.byte_5, i_pix.byte_4, i_pix.byte_3,
                         i_pix.byte_2, i_pix.byte_1, i_pix.byte_0};
                for (int i = 0; i < Channels; i++) begin
                    o_used[i] = (3'(i) < n);
                end
            end
            default: begin
                o_val[0] = i_pix.byte_2;
                o_val[1] = i_pix.byte_1 - i_pix.byte_2;
                o_val[2] = i_pix.byte_1 - i_pix.byte_0;
                o_val[3] = i_pix.byte_3;
                o_used   = (i_cfg.format == FMT_RGBA) ? 6'b001111 : 6'b000111;
            end
        endcase
        // difference against the same channel of the previous pixel, or zero at row start
        for (int i = 0; i < Channels; i++) begin
            prv      = i_row_start ? 8'd0 : i_prev[i];
            o_res[i] = o_used[i] ? (o_val[i] - prv) : 8'd0;
        end
    end
endmodule

// ----- design/pixel_delta_predictor.sv -----
// Pixel delta predictor: one pixel beat in, one residual beat out, one
// pixel per clock unless stalled. A beat is registered on input,
// converted and differenced in one pass, and held in an output register.
// History and the column counter advance at input register unload.
// Configure only while idle. Depends on pdp_pkg, pdp_datapath, pdp_depth.
module pixel_delta_predictor import pdp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_pix_in     i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_pix_out    o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    t_cfg                     r_cfg;
    t_pix_in                  r_pix;
    logic                     r_pv;
    logic                     r_ov;
    t_pix_out                 r_out;
    logic [Channels-1:0][7:0] r_prev;
    logic [15:0]              r_col;

    logic [Channels-1:0][7:0] val;
    logic [Channels-1:0]      used;
    logic [Channels-1:0][7:0] res;
    logic                     adv;
    logic [15:0]              n_col;
    logic [15:0]              width;
    logic                     last;

    assign o_cfg_ready = 1'b1;
    assign adv     = r_pv && (!r_ov || i_ready);
    assign o_ready = !r_pv || adv;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    pdp_datapath u_dp (
        .i_pix(r_pix), .i_cfg(r_cfg), .i_row_start(r_col == 16'd0),
        .i_prev(r_prev), .o_val(val), .o_used(used), .o_res(res)
    );

    always_comb begin
        width = (r_cfg.row_width == 16'd0) ? 16'd1 : r_cfg.row_width;
        n_col = r_col + 16'd1;
        last  = (n_col >= width) || (n_col == 16'd0);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{format: FMT_DEPTH, plane_count: 3'd1, row_width: 16'd1};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FORMAT: r_cfg.format      <= i_cfg_data[1:0];
                REG_PLANES: r_cfg.plane_count <= i_cfg_data[2:0];
                REG_WIDTH:  r_cfg.row_width   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register, output register, history and column counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_ov   <= 1'b0;
            r_col  <= '0;
            r_prev <= '0;
        end else begin
            if (o_ready) begin
                r_pv <= i_valid;
            end
            if (adv) begin
                r_ov  <= 1'b1;
                r_col <= last ? 16'd0 : n_col;
                for (int i = 0; i < Channels; i++) begin
                    if (used[i]) begin
                        r_prev[i] <= val[i];
                    end else if (r_col == 16'd0) begin
                        r_prev[i] <= 8'd0;
                    end
                end
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pix <= i_data;
        end
        if (adv) begin
            r_out <= '{res_5: res[5], res_4: res[4], res_3: res[3], res_2: res[2],
                       res_1: res[1], res_0: res[0], last_in_row: last};
        end
    end

    a_col_lt_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (r_col < width) || !$stable(r_cfg.row_width))
        else $error("column counter past row width");
    a_last_resets_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && last |=> r_col == 16'd0)
        else $error("column counter not cleared after row end");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_ready |=> r_ov && $stable(r_out))
        else $error("stalled result lost");
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for pixel_delta_predictor: directed and random pixel
// traffic over all formats, with random row widths and plane counts, checked beat by beat.
// Depends on pdp_pkg and the pixel_delta_predictor RTL.
`timescale 1ns / 1ps

import pdp_pkg::*;

// Residual predictor: mirrors the block's history, column counter and registers
class residual_predictor;
    logic [1:0]  fmt;
    logic [2:0]  planes;
    logic [15:0] width;
    logic [7:0]  history [Channels];
    logic [15:0] column;
    t_pix_out    pending_residuals [$];
    int          mismatches;
    int          checked;

    function new();
        fmt = FMT_DEPTH;
        planes = 3'd1;
        width = 16'd1;
        column = '0;
        mismatches = 0;
        checked = 0;
        foreach (history[i]) history[i] = '0;
    endfunction

    function void write_reg(logic [1:0] index, logic [15:0] data);
        case (index)
            REG_FORMAT: fmt = data[1:0];
            REG_PLANES: planes = data[2:0];
            REG_WIDTH:  width = data;
            default: ;
        endcase
    endfunction

    // Scale a float by 2^24-1 with round-to-nearest-even, then truncate and clamp
    function logic [23:0] depth_fixed(logic [31:0] bits);
        int              e;
        int              s;
        int              k;
        int              len;
        longint unsigned m;
        longint unsigned x;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned half;
        longint unsigned val;
        e = bits[30:23];
        m = bits[22:0];
        if (e == 255) return (m != 0 || bits[31]) ? 24'd0 : DepthMax;
        if (bits[31]) return 24'd0;
        if (e == 0 && m == 0) return 24'd0;
        if (e == 0) e = 1;
        else m = m | (64'd1 << 23);
        x = m * 64'hffffff;
        len = 0;
        while ((x >> len) != 0) len++;
        if (len > 24) begin
            s = len - 24;
            q = x >> s;
            rem = x & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            if (rem > half || (rem == half && q[0])) q++;
        end else begin
            s = 0;
            q = x;
        end
        k = s + e - 150;
        if (k >= 0) begin
            if (k >= 40) return DepthMax;
            val = q << k;
        end else begin
            if (-k >= 64) return 24'd0;
            val = q >> (-k);
        end
        return (val >= 64'hffffff) ? DepthMax : val[23:0];
    endfunction

    // Note an accepted pixel beat and queue its residuals
    function void note_pixel(t_pix_in p);
        logic [7:0]  val [Channels];
        bit          used [Channels];
        logic [7:0]  res [Channels];
        logic [7:0]  raw [Channels];
        logic [23:0] d;
        int          n;
        int          w;
        int          next_col;
        t_pix_out    r;
        w = (width == 0) ? 1 : width;
        raw[0] = p.byte_0; raw[1] = p.byte_1; raw[2] = p.byte_2;
        raw[3] = p.byte_3; raw[4] = p.byte_4; raw[5] = p.byte_5;
        foreach (val[i]) begin
            val[i] = '0;
            used[i] = 0;
        end
        if (column == 0) foreach (history[i]) history[i] = '0;
        case (fmt)
            FMT_DEPTH: begin
                d = depth_fixed(p.depth_bits);
                val[0] = d[7:0]; val[1] = d[15:8]; val[2] = d[23:16];
                used[0] = 1; used[1] = 1; used[2] = 1;
            end
            FMT_PLANE: begin
                n = planes;
                if (n < 1) n = 1;
                if (n > MaxPlanes) n = MaxPlanes;
                for (int i = 0; i < n; i++) begin
                    val[i] = raw[i];
                    used[i] = 1;
                end
            end
            default: begin
                val[0] = p.byte_2;
                val[1] = p.byte_1 - p.byte_2;
                val[2] = p.byte_1 - p.byte_0;
                used[0] = 1; used[1] = 1; used[2] = 1;
                if (fmt == FMT_RGBA) begin
                    val[3] = p.byte_3;
                    used[3] = 1;
                end
            end
        endcase
        foreach (res[i]) begin
            if (used[i]) begin
                res[i] = val[i] - history[i];
                history[i] = val[i];
            end else begin
                res[i] = '0;
            end
        end
        next_col = (column + 1) & 16'hffff;
        r.last_in_row = (next_col >= w || next_col == 0);
        column = r.last_in_row ? 16'd0 : next_col[15:0];
        r.res_0 = res[0]; r.res_1 = res[1]; r.res_2 = res[2];
        r.res_3 = res[3]; r.res_4 = res[4]; r.res_5 = res[5];
        pending_residuals.push_back(r);
    endfunction

    function void cmp_field(string name, int expected, int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            mismatches++;
        end
    endfunction

    // Check a residual beat against the oldest expectation
    function void check_result(t_pix_out got);
        t_pix_out want;
        if (pending_residuals.size() == 0) begin
            $error("unexpected residual beat %h", got);
            mismatches++;
            return;
        end
        want = pending_residuals.pop_front();
        checked++;
        cmp_field("res_0", want.res_0, got.res_0);
        cmp_field("res_1", want.res_1, got.res_1);
        cmp_field("res_2", want.res_2, got.res_2);
        cmp_field("res_3", want.res_3, got.res_3);
        cmp_field("res_4", want.res_4, got.res_4);
        cmp_field("res_5", want.res_5, got.res_5);
        cmp_field("last_in_row", want.last_in_row, got.last_in_row);
    endfunction
endclass

module testbench;
    localparam int CycleLimit = 300000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_pix_in     i_data;
    logic        o_valid;
    logic        i_ready;
    t_pix_out    o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    residual_predictor predictor;
    int send_idle;
    int recv_idle;
    int hold_cycles;
    int pixels_sent;
    int cfg_writes;

    pixel_delta_predictor i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        repeat (CycleLimit) @(posedge i_clk);
        $display("testbench NOT OK");
        $finish;
    end

    // Accept residual beats; stall at random or for a requested hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) predictor.check_result(o_data);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // Offer one pixel beat, with random idle cycles ahead of it
    task automatic send_pixel(t_pix_in p);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= p;
        do @(posedge i_clk); while (!o_ready);
        predictor.note_pixel(p);
        pixels_sent++;
    endtask

    // Wait until every residual is back and the pipeline is empty
    task automatic drain();
        i_valid <= 1'b0;
        while (predictor.pending_residuals.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [15:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        predictor.write_reg(index, data);
        cfg_writes++;
    endtask

    function automatic t_pix_in random_pixel();
        t_pix_in p;
        p = 80'({$urandom, $urandom, $urandom});
        // Mostly depths in [0, 1], where the fixed value is not clamped
        if ($urandom_range(3) != 0) p.depth_bits = $urandom_range(32'h3f800000);
        if ($urandom_range(7) == 0) p.depth_bits = 32'h3f800000 + $urandom_range(64);
        return p;
    endfunction

    task automatic send_depth(logic [31:0] bits);
        t_pix_in p;
        p = random_pixel();
        p.depth_bits = bits;
        send_pixel(p);
    endtask

    task automatic send_bytes(logic [7:0] b);
        t_pix_in p;
        p = random_pixel();
        p.byte_0 = b; p.byte_1 = b; p.byte_2 = b;
        p.byte_3 = b; p.byte_4 = b; p.byte_5 = b;
        send_pixel(p);
    endtask

    // Random phase: fresh registers, then a run of random pixels
    task automatic random_phase(int count);
        int w;
        case ($urandom_range(9))
            0: w = 65535;
            1: w = 0;
            2: w = 1;
            3: w = $urandom_range(65535);
            default: w = $urandom_range(2, 9);
        endcase
        write_reg(REG_FORMAT, 16'($urandom));
        write_reg(REG_PLANES, 16'($urandom));
        write_reg(REG_WIDTH, 16'(w));
        repeat (count) send_pixel(random_pixel());
    endtask

    initial begin
        int total;
        predictor = new();
        send_idle = 0;
        recv_idle = 0;
        hold_cycles = 0;
        pixels_sent = 0;
        cfg_writes = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_FORMAT;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Depth extremes: zeros, one, infinity, NaN, negatives, tiny, huge
        write_reg(REG_WIDTH, 16'd4);
        send_depth(32'h00000000);
        send_depth(32'h80000000);
        send_depth(32'h3f800000);
        send_depth(32'h7f800000);
        send_depth(32'h7fc00000);
        send_depth(32'hbf800000);
        send_depth(32'h7f7fffff);
        send_depth(32'h00000001);
        send_depth(32'h3f7fffff);
        send_depth(32'hffffffff);
        // Byte planes with plane counts below and above range
        write_reg(REG_FORMAT, 16'(FMT_PLANE));
        write_reg(REG_PLANES, 16'd0);
        send_bytes(8'hff);
        send_bytes(8'h00);
        write_reg(REG_PLANES, 16'd7);
        send_bytes(8'hff);
        send_bytes(8'h00);
        // Color transforms; zero row width makes every pixel a row
        write_reg(REG_FORMAT, 16'(FMT_RGB));
        write_reg(REG_WIDTH, 16'd0);
        send_bytes(8'hff);
        send_bytes(8'h01);
        write_reg(REG_FORMAT, 16'(FMT_RGBA));
        write_reg(REG_WIDTH, 16'd8);
        send_bytes(8'h80);
        send_bytes(8'h7f);
        send_bytes(8'hff);
        // Lower the width in mid row: the row must close at once
        write_reg(REG_WIDTH, 16'd2);
        send_bytes(8'h00);
        send_bytes(8'h55);

        // Random part over three idle regimes
        total = 0;
        while (total < 2000) begin
            if (total < 650) begin
                send_idle = 8;
                recv_idle = 72;
            end else if (total < 1300) begin
                send_idle = 72;
                recv_idle = 8;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (total == 1400) begin
                // Long receiver hold-off while pixels keep coming
                write_reg(REG_FORMAT, 16'(FMT_PLANE));
                write_reg(REG_PLANES, 16'd6);
                hold_cycles = 200;
                repeat (40) send_pixel(random_pixel());
                // Sender pauses until the block has emptied out
                drain();
                total += 40;
            end
            random_phase(($urandom_range(7) == 0) ? 150 : $urandom_range(10, 60));
            total += 50;
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("covered %0d pixels, %0d residual checks, %0d register writes",
                 pixels_sent, predictor.checked, cfg_writes);
        $display("formats depth/planes/rgb/rgba, widths 0..65535, stalls and hold-offs");
        if (predictor.mismatches == 0 && predictor.pending_residuals.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
design/pdp_pkg.sv
design/pdp_depth.sv
design/pdp_datapath.sv
design/pixel_delta_predictor.sv
tb/testbench.sv
